### rtl/packet_header_normalizer_macros.svh
// Assertion macros shared by the header normalizer RTL.
`ifndef PACKET_HEADER_NORMALIZER_MACROS_SVH
`define PACKET_HEADER_NORMALIZER_MACROS_SVH

// Check that cons holds in every cycle where ante holds.
`define PHN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packet_header_normalizer: invariant violated");

// Check that cons holds in the first cycle after reset is released.
`define PHN_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $past(!rst_n) |-> (cons)) \
    else $error("packet_header_normalizer: bad state after reset");

`endif

### rtl/phn_pkg.sv
// Types and constants of the packet header normalizer.
package phn_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_ETH    = 3'd0,
    PH_IP     = 3'd1,
    PH_L4     = 3'd2,
    PH_DONE   = 3'd3,
    PH_REJECT = 3'd4
  } phase_t;

  // Verdict codes
  typedef enum logic [1:0] {
    VERD_ACCEPT   = 2'd0,
    VERD_NOT_IPV4 = 2'd1,
    VERD_NOT_L4   = 2'd2,
    VERD_TRUNC    = 2'd3
  } verdict_t;

  localparam logic [5:0]  HDR_SLOT      = 6'd60;
  localparam logic [5:0]  TCP_TAIL      = 6'd8;
  localparam logic [6:0]  UDP_LEN       = 7'd8;
  localparam logic [5:0]  ETYPE_HI_OFS  = 6'd12;
  localparam logic [5:0]  ETYPE_LO_OFS  = 6'd13;
  localparam logic [5:0]  VLAN_RESUME   = 6'd10;
  localparam logic [5:0]  IP_VHL_OFS    = 6'd0;
  localparam logic [5:0]  IP_PROTO_OFS  = 6'd9;
  localparam logic [5:0]  TCP_DOFF_OFS  = 6'd12;
  localparam logic [15:0] ETYPE_VLAN    = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

  // One run of results caused by one input byte:
  // an optional lead item, a run of zero bytes, an optional closing verdict.
  typedef struct packed {
    logic       lead_v;
    logic [7:0] lead_byte;
    logic       lead_isv;
    verdict_t   lead_verd;
    logic [5:0] zcnt;
    logic       tail_v;
    verdict_t   tail_verd;
  } run_t;

endpackage

### rtl/phn_if.sv
// Valid/ready channel interfaces for frame bytes in and blob items out.
interface phn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface phn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blob_byte;
  logic       is_verdict;
  logic [1:0] verdict;
  logic       run_last;

  modport source (output valid, output blob_byte, output is_verdict, output verdict,
                  output run_last, input ready);
  modport sink   (input valid, input blob_byte, input is_verdict, input verdict,
                  input run_last, output ready);
endinterface

### rtl/packet_header_normalizer.sv
// Packet header normalizer top level.
//
// in_beat carries one Ethernet frame byte per beat, frame_last on the final
// byte. out_beat delivers the normalized 128-byte header blob (IPv4 header
// padded to 60, TCP header padded to 60 plus 8 zeros or UDP header plus 60
// zeros) and one verdict beat: accepted, not IPv4, not TCP/UDP or truncated.
// run_last marks the last result beat caused by one input byte.
// An accepted byte's run is registered before it is shown. Results leave
// at one beat per cycle unless the receiver stalls; a byte that ends a
// header causes a run of up to 62 beats, set by the single result counter.
// Input throughput is one byte per cycle while runs drain as fast as they
// are made; one further run may queue behind the active one, after which
// in_beat.ready drops until the active run finishes.
// Bytes that cause no result (Ethernet header, payload) are taken at one
// per cycle whenever no run is queued, whatever the output does.
// Reset (synchronous, active low) empties both runs and returns the parser
// to the Ethernet header; no clearing pass is needed.
// When the receiver stalls, the current beat holds on out_beat.
`include "packet_header_normalizer_macros.svh"

module packet_header_normalizer (
  input  logic      clk,
  input  logic      rst_n,
  phn_in_if.sink    in_beat,
  phn_out_if.source out_beat
);
  import phn_pkg::*;

  run_t run;
  logic run_v;
  logic run_ready;
  logic beat_acc;
  logic verd_beat;
  logic verd_clean;
  logic blob_beat;

  // Take a byte whenever the run queue has room
  assign in_beat.ready = run_ready;
  assign beat_acc      = in_beat.valid && run_ready;

  phn_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_acc   (beat_acc),
    .frame_byte (in_beat.frame_byte),
    .frame_last (in_beat.frame_last),
    .run        (run),
    .run_v      (run_v)
  );

  phn_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_v     (run_v),
    .run       (run),
    .run_ready (run_ready),
    .out_beat  (out_beat)
  );

  // Checks
  assign verd_beat  = out_beat.valid && out_beat.is_verdict;
  assign verd_clean = out_beat.run_last && (out_beat.blob_byte == 8'd0);
  assign blob_beat  = out_beat.valid && !out_beat.is_verdict;

  `PHN_ASSERT_IMPL(a_verdict_ends_run, clk, rst_n, verd_beat, verd_clean)
  `PHN_ASSERT_IMPL(a_blob_no_verdict, clk, rst_n, blob_beat, out_beat.verdict == VERD_ACCEPT)
  `PHN_ASSERT_IMPL(a_stall_has_output, clk, rst_n, !in_beat.ready, out_beat.valid)
  `PHN_ASSERT_AFTER_RESET(a_reset_idle, clk, rst_n, !out_beat.valid && in_beat.ready)

endmodule

### rtl/phn_parser.sv
// Header parser: frame state registers and the run descriptor of each byte.
module phn_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          beat_acc,
  input  logic [7:0]    frame_byte,
  input  logic          frame_last,
  output phn_pkg::run_t run,
  output logic          run_v
);
  import phn_pkg::*;

  phase_t     phase_r, phase_nxt, phase_step;
  logic [5:0] byte_count_r, byte_count_nxt;
  logic [5:0] ip_len_r, ip_len_nxt;
  logic [5:0] tcp_len_r, tcp_len_nxt;
  logic       is_tcp_r, is_tcp_nxt;
  logic [7:0] type_hi_r, type_hi_nxt;
  logic       vlan_seen_r, vlan_seen_nxt;

  logic [5:0]  idx_inc;
  logic [6:0]  idx_p1;
  logic [15:0] etype;
  logic [3:0]  ihl_eff, doff_eff;
  logic [5:0]  ip_len_eff, tcp_len_eff;
  logic        vlan_skip, eth_ipv4, eth_bad, proto_bad, ip_end, tcp_end, udp_end;

  // Decode the current byte against the frame position
  assign idx_inc     = byte_count_r + 6'd1;
  assign idx_p1      = {1'b0, byte_count_r} + 7'd1;
  assign etype       = {type_hi_r, frame_byte};
  assign ihl_eff     = (frame_byte[3:0] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : frame_byte[3:0];
  assign doff_eff    = (frame_byte[7:4] < MIN_HDR_WORDS) ? MIN_HDR_WORDS : frame_byte[7:4];
  assign ip_len_eff  = (byte_count_r == IP_VHL_OFS) ? {ihl_eff, 2'b00} : ip_len_r;
  assign tcp_len_eff = (byte_count_r == TCP_DOFF_OFS) ? {doff_eff, 2'b00} : tcp_len_r;
  assign vlan_skip   = (byte_count_r == ETYPE_LO_OFS) && (etype == ETYPE_VLAN) && !vlan_seen_r;
  assign eth_ipv4    = (byte_count_r == ETYPE_LO_OFS) && (etype == ETYPE_IPV4);
  assign eth_bad     = (byte_count_r == ETYPE_LO_OFS) && !vlan_skip && !eth_ipv4;
  assign proto_bad   = (byte_count_r == IP_PROTO_OFS) && (frame_byte != PROTO_TCP)
                       && (frame_byte != PROTO_UDP);
  assign ip_end      = idx_p1 >= {1'b0, ip_len_eff};
  assign tcp_end     = (byte_count_r >= TCP_DOFF_OFS) && (idx_p1 >= {1'b0, tcp_len_eff});
  assign udp_end     = idx_p1 >= UDP_LEN;

  // Next state: advance through the headers, drop back to reset on frame end
  always_comb begin
    phase_step     = phase_r;
    byte_count_nxt = byte_count_r;
    ip_len_nxt     = ip_len_r;
    tcp_len_nxt    = tcp_len_r;
    is_tcp_nxt     = is_tcp_r;
    type_hi_nxt    = type_hi_r;
    vlan_seen_nxt  = vlan_seen_r;
    unique case (phase_r)
      PH_ETH: begin
        if (byte_count_r == ETYPE_HI_OFS) begin
          type_hi_nxt    = frame_byte;
          byte_count_nxt = idx_inc;
        end else if (byte_count_r == ETYPE_LO_OFS) begin
          if (vlan_skip) begin
            vlan_seen_nxt  = 1'b1;
            byte_count_nxt = VLAN_RESUME;
          end else if (eth_ipv4) begin
            phase_step     = PH_IP;
            byte_count_nxt = '0;
          end else begin
            phase_step = PH_REJECT;
          end
        end else begin
          byte_count_nxt = idx_inc;
        end
      end
      PH_IP: begin
        ip_len_nxt = ip_len_eff;
        if (proto_bad) begin
          phase_step = PH_REJECT;
        end else begin
          if (byte_count_r == IP_PROTO_OFS) begin
            is_tcp_nxt = (frame_byte == PROTO_TCP);
          end
          if (ip_end) begin
            phase_step     = PH_L4;
            byte_count_nxt = '0;
          end else begin
            byte_count_nxt = idx_inc;
          end
        end
      end
      PH_L4: begin
        if (is_tcp_r) begin
          tcp_len_nxt = tcp_len_eff;
          if (tcp_end) begin
            phase_step = PH_DONE;
          end else begin
            byte_count_nxt = idx_inc;
          end
        end else if (udp_end) begin
          phase_step = PH_DONE;
        end else begin
          byte_count_nxt = idx_inc;
        end
      end
      default: begin
      end
    endcase

    phase_nxt = phase_step;
    if (frame_last) begin
      phase_nxt      = PH_ETH;
      byte_count_nxt = '0;
      ip_len_nxt     = '0;
      tcp_len_nxt    = '0;
      is_tcp_nxt     = 1'b0;
      type_hi_nxt    = '0;
      vlan_seen_nxt  = 1'b0;
    end
  end

  // Run descriptor of the current byte
  always_comb begin
    run = '0;
    unique case (phase_r)
      PH_ETH: begin
        if (eth_bad) begin
          run.lead_v    = 1'b1;
          run.lead_isv  = 1'b1;
          run.lead_verd = VERD_NOT_IPV4;
        end
      end
      PH_IP: begin
        run.lead_v = 1'b1;
        if (proto_bad) begin
          run.lead_isv  = 1'b1;
          run.lead_verd = VERD_NOT_L4;
        end else begin
          run.lead_byte = frame_byte;
          if (ip_end) begin
            run.zcnt = HDR_SLOT - ip_len_eff;
          end
        end
      end
      PH_L4: begin
        run.lead_v    = 1'b1;
        run.lead_byte = frame_byte;
        if (is_tcp_r && tcp_end) begin
          run.zcnt      = HDR_SLOT - tcp_len_eff + TCP_TAIL;
          run.tail_v    = 1'b1;
          run.tail_verd = VERD_ACCEPT;
        end else if (!is_tcp_r && udp_end) begin
          run.zcnt      = HDR_SLOT;
          run.tail_v    = 1'b1;
          run.tail_verd = VERD_ACCEPT;
        end
      end
      default: begin
      end
    endcase
    // Close an unfinished frame with a truncated verdict
    if (frame_last && (phase_step != PH_DONE) && (phase_step != PH_REJECT)) begin
      run.tail_v    = 1'b1;
      run.tail_verd = VERD_TRUNC;
    end
  end

  assign run_v = beat_acc && (run.lead_v || run.tail_v);

  // Hold frame state between accepted bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ETH;
      byte_count_r <= '0;
      ip_len_r     <= '0;
      tcp_len_r    <= '0;
      is_tcp_r     <= 1'b0;
      type_hi_r    <= '0;
      vlan_seen_r  <= 1'b0;
    end else if (beat_acc) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      ip_len_r     <= ip_len_nxt;
      tcp_len_r    <= tcp_len_nxt;
      is_tcp_r     <= is_tcp_nxt;
      type_hi_r    <= type_hi_nxt;
      vlan_seen_r  <= vlan_seen_nxt;
    end
  end

endmodule

### rtl/phn_emitter.sv
// Run emitter: one queued run, one active run, one result beat per cycle unless stalled.
module phn_emitter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          run_v,
  input  phn_pkg::run_t run,
  output logic          run_ready,
  phn_out_if.source     out_beat
);
  import phn_pkg::*;

  run_t job_r, job_nxt;
  run_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  logic job_act, item_last, out_acc, job_can_load;

  // Pick the current item of the active run
  assign job_act   = job_r.lead_v || (job_r.zcnt != '0) || job_r.tail_v;
  assign item_last = job_r.lead_v ? ((job_r.zcnt == '0) && !job_r.tail_v)
                                  : ((job_r.zcnt == 6'd1 && !job_r.tail_v)
                                     || (job_r.zcnt == '0));
  assign out_acc      = out_beat.valid && out_beat.ready;
  assign job_can_load = !job_act || (out_acc && item_last);
  assign run_ready    = !pend_v_r;

  always_comb begin
    out_beat.valid      = job_act;
    out_beat.run_last   = item_last;
    out_beat.blob_byte  = '0;
    out_beat.is_verdict = 1'b0;
    out_beat.verdict    = VERD_ACCEPT;
    if (job_r.lead_v) begin
      out_beat.blob_byte  = job_r.lead_byte;
      out_beat.is_verdict = job_r.lead_isv;
      out_beat.verdict    = job_r.lead_verd;
    end else if (job_r.zcnt == '0) begin
      out_beat.is_verdict = 1'b1;
      out_beat.verdict    = job_r.tail_verd;
    end
  end

  // Advance the active run, load the next one from the input or the queue
  always_comb begin
    job_nxt    = job_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    if (out_acc) begin
      if (job_r.lead_v) begin
        job_nxt.lead_v = 1'b0;
      end else if (job_r.zcnt != '0) begin
        job_nxt.zcnt = job_r.zcnt - 6'd1;
      end else begin
        job_nxt.tail_v = 1'b0;
      end
    end
    priority if (run_v && run_ready) begin
      if (job_can_load) begin
        job_nxt = run;
      end else begin
        pend_nxt   = run;
        pend_v_nxt = 1'b1;
      end
    end else if (pend_v_r && job_can_load) begin
      job_nxt    = pend_r;
      pend_v_nxt = 1'b0;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      job_r    <= job_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Queued run payload
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Testbench of the packet header normalizer: random frames in, blob and verdict beats checked.
module testbench;
  import phn_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam int RAND_BYTES  = 205;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } frame_beat_t;

  typedef struct {
    logic [7:0] blob_byte;
    logic       is_verdict;
    verdict_t   verdict;
    logic       run_last;
  } blob_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  phn_in_if  in_ch();
  phn_out_if out_ch();

  packet_header_normalizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch)
  );

  always #5 clk = ~clk;

  // Parser state mirrored from the byte stream
  phase_t     parse_phase;
  logic [5:0] hdr_pos;
  logic [5:0] ip_len;
  logic [5:0] tcp_len;
  logic       l4_is_tcp;
  logic [7:0] etype_hi;
  logic       vlan_skipped;

  blob_item_t  blob_expect[$];
  frame_beat_t frame_beats[$];
  logic [7:0]  frame_buf[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  bit timed_out   = 1'b0;

  int in_stretch  = 0;
  bit in_idling   = 1'b0;
  int out_stretch = 0;
  bit out_idling  = 1'b0;

  // Draw an idle count; each stretch either idles or runs flat out, chosen at random.
  function automatic int draw_idle(inout int stretch, inout bit idling);
    if (stretch == 0) begin
      stretch = $urandom_range(8, 48);
      idling  = ($urandom_range(0, 2) != 0);
    end
    stretch--;
    return idling ? int'($urandom_range(0, 19)) : 0;
  endfunction

  task automatic reset_parser();
    parse_phase  = PH_ETH;
    hdr_pos      = '0;
    ip_len       = '0;
    tcp_len      = '0;
    l4_is_tcp    = 1'b0;
    etype_hi     = '0;
    vlan_skipped = 1'b0;
  endtask

  function automatic void push_blob(logic [7:0] b, logic isv, verdict_t v);
    blob_item_t it;
    it.blob_byte  = b;
    it.is_verdict = isv;
    it.verdict    = v;
    it.run_last   = 1'b0;
    blob_expect.push_back(it);
  endfunction

  function automatic void push_zeros(int n);
    for (int i = 0; i < n; i++) push_blob(8'h00, 1'b0, VERD_ACCEPT);
  endfunction

  // Advance the parser by one frame byte and queue the beats it causes.
  task automatic predict_blob(input logic [7:0] b, input logic last);
    int          base;
    int          pos;
    int          words;
    logic [15:0] etype;
    base = blob_expect.size();
    pos  = int'(hdr_pos);
    case (parse_phase)
      PH_ETH: begin
        if (hdr_pos == ETYPE_HI_OFS) begin
          etype_hi = b;
          hdr_pos  = hdr_pos + 6'd1;
        end else if (hdr_pos == ETYPE_LO_OFS) begin
          etype = {etype_hi, b};
          if (etype == ETYPE_VLAN && !vlan_skipped) begin
            // skip the tag control, then read the ethertype again
            vlan_skipped = 1'b1;
            hdr_pos      = VLAN_RESUME;
          end else if (etype == ETYPE_IPV4) begin
            parse_phase = PH_IP;
            hdr_pos     = '0;
          end else begin
            push_blob(8'h00, 1'b1, VERD_NOT_IPV4);
            parse_phase = PH_REJECT;
          end
        end else begin
          hdr_pos = hdr_pos + 6'd1;
        end
      end
      PH_IP: begin
        if (hdr_pos == IP_VHL_OFS) begin
          words  = (b[3:0] < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(b[3:0]);
          ip_len = 6'(words * 4);
        end
        if (hdr_pos == IP_PROTO_OFS && b != PROTO_TCP && b != PROTO_UDP) begin
          // drop the protocol byte, emit the verdict only
          push_blob(8'h00, 1'b1, VERD_NOT_L4);
          parse_phase = PH_REJECT;
        end else begin
          if (hdr_pos == IP_PROTO_OFS) l4_is_tcp = (b == PROTO_TCP);
          push_blob(b, 1'b0, VERD_ACCEPT);
          if (pos + 1 >= int'(ip_len)) begin
            push_zeros(int'(HDR_SLOT) - int'(ip_len));
            parse_phase = PH_L4;
            hdr_pos     = '0;
          end else begin
            hdr_pos = hdr_pos + 6'd1;
          end
        end
      end
      PH_L4: begin
        push_blob(b, 1'b0, VERD_ACCEPT);
        if (l4_is_tcp) begin
          if (hdr_pos == TCP_DOFF_OFS) begin
            words   = (b[7:4] < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(b[7:4]);
            tcp_len = 6'(words * 4);
          end
          if (pos >= int'(TCP_DOFF_OFS) && pos + 1 >= int'(tcp_len)) begin
            push_zeros(int'(HDR_SLOT) - int'(tcp_len) + int'(TCP_TAIL));
            push_blob(8'h00, 1'b1, VERD_ACCEPT);
            parse_phase = PH_DONE;
          end else begin
            hdr_pos = hdr_pos + 6'd1;
          end
        end else if (pos + 1 >= int'(UDP_LEN)) begin
          push_zeros(int'(HDR_SLOT));
          push_blob(8'h00, 1'b1, VERD_ACCEPT);
          parse_phase = PH_DONE;
        end else begin
          hdr_pos = hdr_pos + 6'd1;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (parse_phase != PH_DONE && parse_phase != PH_REJECT)
        push_blob(8'h00, 1'b1, VERD_TRUNC);
      reset_parser();
    end
    if (blob_expect.size() > base) blob_expect[blob_expect.size() - 1].run_last = 1'b1;
  endtask

  function automatic void push_beat(logic [7:0] data, logic last, bit drain);
    frame_beat_t fb;
    fb.data  = data;
    fb.last  = last;
    fb.drain = drain;
    fb.gap   = draw_idle(in_stretch, in_idling);
    frame_beats.push_back(fb);
  endfunction

  // Queue the first keep bytes of the frame buffer as one frame.
  function automatic int send_frame(int keep, bit drain);
    for (int i = 0; i < keep; i++) push_beat(frame_buf[i], i == keep - 1, drain && i == 0);
    frame_buf.delete();
    return keep;
  endfunction

  // Assemble a frame: MACs, VLAN tags, ethertype, IPv4 and L4 headers, payload.
  function automatic void build_frame(int tags, logic [15:0] etype, logic [3:0] ihl,
                                      logic [7:0] proto, logic [3:0] doff, int tail);
    int words;
    for (int i = 0; i < 12; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    for (int t = 0; t < tags; t++) begin
      frame_buf.push_back(ETYPE_VLAN[15:8]);
      frame_buf.push_back(ETYPE_VLAN[7:0]);
      frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    frame_buf.push_back(etype[15:8]);
    frame_buf.push_back(etype[7:0]);
    if (etype == ETYPE_IPV4) begin
      words = (ihl < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(ihl);
      for (int i = 0; i < words * 4; i++) begin
        if (i == int'(IP_VHL_OFS)) frame_buf.push_back({4'($urandom_range(0, 15)), ihl});
        else if (i == int'(IP_PROTO_OFS)) frame_buf.push_back(proto);
        else frame_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (proto == PROTO_TCP) begin
        words = (doff < MIN_HDR_WORDS) ? int'(MIN_HDR_WORDS) : int'(doff);
        for (int i = 0; i < words * 4; i++) begin
          if (i == int'(TCP_DOFF_OFS)) frame_buf.push_back({doff, 4'($urandom_range(0, 15))});
          else frame_buf.push_back(8'($urandom_range(0, 255)));
        end
      end else if (proto == PROTO_UDP) begin
        for (int i = 0; i < int'(UDP_LEN); i++) frame_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < tail; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Frame byte driver: honor the drawn gap, hold a drain-marked beat until all results are in
  int gap_left  = 0;
  bit gap_armed = 1'b0;

  always @(posedge clk) begin
    frame_beat_t nb;
    logic        next_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_armed = 1'b0;
      gap_left  = 0;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_blob(in_ch.frame_byte, in_ch.frame_last);
        next_valid = 1'b0;
      end
      if (!next_valid && frame_beats.size() > 0) begin
        if (!gap_armed) begin
          gap_left  = frame_beats[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(frame_beats[0].drain && blob_expect.size() != 0)) begin
          nb = frame_beats.pop_front();
          in_ch.frame_byte <= nb.data;
          in_ch.frame_last <= nb.last;
          next_valid = 1'b1;
          gap_armed  = 1'b0;
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // Result monitor: compare each beat with the oldest expectation, then stall at random
  int stall_left = 0;

  always @(posedge clk) begin
    blob_item_t want;
    logic       next_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (blob_expect.size() == 0) begin
          $display("%0t: unexpected beat byte=%02h isv=%0b verdict=%0d run_last=%0b",
                   $time, out_ch.blob_byte, out_ch.is_verdict, out_ch.verdict,
                   out_ch.run_last);
          mismatches++;
        end else begin
          want = blob_expect.pop_front();
          if ({out_ch.blob_byte, out_ch.is_verdict, out_ch.verdict, out_ch.run_last} !==
              {want.blob_byte, want.is_verdict, want.verdict, want.run_last}) begin
            $display("%0t: mismatch expected byte=%02h isv=%0b verdict=%0d run_last=%0b",
                     $time, want.blob_byte, want.is_verdict, want.verdict, want.run_last);
            $display("%0t:          actual   byte=%02h isv=%0b verdict=%0d run_last=%0b",
                     $time, out_ch.blob_byte, out_ch.is_verdict, out_ch.verdict,
                     out_ch.run_last);
            mismatches++;
          end
        end
        stall_left = draw_idle(out_stretch, out_idling);
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      if (!timed_out) $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      timed_out <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          rand_bytes;
    int          frame_no;
    int          kind;
    int          tags;
    int          keep;
    int          tail;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    in_ch.valid      = 1'b0;
    in_ch.frame_byte = 8'h00;
    in_ch.frame_last = 1'b0;
    out_ch.ready     = 1'b0;
    reset_parser();

    // Lone byte marked last: truncated at once
    frame_buf.push_back(8'hFF);
    void'(send_frame(1, 1'b0));
    // Unknown ethertype on the final byte: reject and frame end together
    for (int i = 0; i < 12; i++) frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'hFF);
    void'(send_frame(14, 1'b0));
    // Frame cut inside the Ethernet header
    for (int i = 0; i < 10; i++) frame_buf.push_back((i % 2 == 0) ? 8'h55 : 8'hAA);
    void'(send_frame(10, 1'b0));

    // Random frames; the first few walk the main cases, later ones are mostly well formed
    rand_bytes = 0;
    frame_no   = 0;
    while (rand_bytes < RAND_BYTES) begin
      kind = (frame_no < 4) ? frame_no : int'($urandom_range(0, 9));
      tags = ($urandom_range(0, 3) == 0) ? 1 : 0;
      ihl  = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : MIN_HDR_WORDS;
      doff = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : MIN_HDR_WORDS;
      tail = $urandom_range(0, 4);
      case (kind)
        0: begin
          // tagged TCP with header lengths below the minimum
          build_frame(1, ETYPE_IPV4, 4'($urandom_range(0, 4)), PROTO_TCP,
                      4'($urandom_range(0, 4)), tail);
        end
        1, 7: begin
          build_frame(tags, ETYPE_IPV4, ihl, PROTO_UDP, doff, tail);
        end
        2: begin
          proto = 8'($urandom_range(0, 255));
          if (proto == PROTO_TCP || proto == PROTO_UDP) proto = 8'hFF;
          build_frame(tags, ETYPE_IPV4, ihl, proto, doff, tail);
        end
        3: begin
          // a second VLAN tag is not skipped
          build_frame(2, ETYPE_IPV4, MIN_HDR_WORDS, PROTO_TCP, MIN_HDR_WORDS, 0);
        end
        4, 5, 6: begin
          build_frame(tags, ETYPE_IPV4, ihl, PROTO_TCP, doff, tail);
        end
        8: begin
          build_frame(tags, 16'($urandom_range(0, 65535)), ihl, PROTO_TCP, doff, tail);
        end
        default: begin
          for (int i = 0; i < int'($urandom_range(1, 24)); i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      keep = frame_buf.size();
      if ($urandom_range(0, 3) == 0) keep = $urandom_range(1, keep);
      // cut the final frame so the byte budget is not overrun
      if (keep > RAND_BYTES - rand_bytes) keep = RAND_BYTES - rand_bytes;
      rand_bytes += send_frame(keep, frame_no == 1 || $urandom_range(0, 4) == 0);
      frame_no++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain stimulus and results, then allow the block to settle
    while (!timed_out && (frame_beats.size() != 0 || in_ch.valid || blob_expect.size() != 0))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (blob_expect.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, blob_expect.size());
      mismatches++;
    end
    if (!timed_out && mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
